// File: rtl/lbw_pkg.sv
package lbw_pkg;

	localparam logic [2:0] OP_STROBE       = 3'd0;
	localparam logic [2:0] OP_SAW          = 3'd1;
	localparam logic [2:0] OP_TRIANGLE     = 3'd2;
	localparam logic [2:0] OP_BREATH       = 3'd3;
	localparam logic [2:0] OP_BREATH_FLOOR = 3'd4;

	localparam logic [7:0] MAX_LEVEL = 8'd255;

	// one reduced transaction handed from the front to the back
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] r;
		logic [15:0] per;
		logic [7:0]  flr;
	} item_t;

endpackage

// File: rtl/lbw_front.sv
module lbw_front
	import lbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic signed [31:0] phase_offset,
	input  logic [15:0] cycle_length,
	input  logic [7:0]  floor_level,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_data
);

	localparam int STEPS = 32;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] per;
		logic [7:0]  flr;
		logic [15:0] rem;
		logic [31:0] dvd;
	} fe_t;

	fe_t              md_s  [STEPS+1];
	logic [STEPS:0]   vld_s;
	logic             en;

	function automatic fe_t mod_step(fe_t a);
		fe_t         b;
		logic [16:0] t;
		b = a;
		t = {a.rem, a.dvd[31]};
		if (t >= {1'b0, a.per}) begin
			t = t - {1'b0, a.per};
		end
		b.rem = t[15:0];
		b.dvd = {a.dvd[30:0], 1'b0};
		return b;
	endfunction

	assign en       = !(vld_s[STEPS] && q_full);
	assign in_stall = !en;
	assign q_push   = vld_s[STEPS] && !q_full;
	assign q_data   = '{op: md_s[STEPS].op, r: md_s[STEPS].rem,
		per: md_s[STEPS].per, flr: md_s[STEPS].flr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STEPS-1:0], in_valid};
		end
	end

	// elapsed time with 32-bit wrap, then one remainder bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			md_s[0].op  <= opcode;
			md_s[0].per <= (cycle_length == 16'd0) ? 16'd1 : cycle_length;
			md_s[0].flr <= floor_level;
			md_s[0].rem <= '0;
			md_s[0].dvd <= now_ms - 32'(phase_offset);
			for (int i = 1; i <= STEPS; i++) begin
				md_s[i] <= mod_step(md_s[i-1]);
			end
		end
	end

endmodule

// File: rtl/lbw_fifo.sv
module lbw_fifo
	import lbw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output item_t rdata
);

	localparam int DEPTH = 4;
	localparam int AW    = 2;

	item_t         mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH)) else $error("fifo count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && count_q == '0)) else $error("pop from empty fifo");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count not grown");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("count not shrunk");

endmodule

// File: rtl/lbw_back.sv
module lbw_back
	import lbw_pkg::*;
#(
	parameter int COSINE_TABLE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  item_t      q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] brightness
);

	localparam int AW = $clog2(COSINE_TABLE_DEPTH);
	localparam int QW = (AW > 9) ? AW : 9;
	localparam int NW = 16 + QW;
	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF   = 64'd1 << 29;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] DEN_NEAR   = 64'(COSINE_TABLE_DEPTH);
	localparam logic [63:0] DEN_FAR    = 64'(2 * COSINE_TABLE_DEPTH);

	typedef struct packed {
		logic [2:0]    op;
		logic [7:0]    flr;
		logic          hz;
		logic          lt;
		logic [15:0]   dsr;
		logic [15:0]   rem;
		logic [QW-1:0] dvd;
	} be_t;

	function automatic logic [63:0] clamp_sub(logic [63:0] s);
		return (s >= Q30_ONE) ? 64'd0 : (Q30_ONE - s);
	endfunction

	function automatic logic [63:0] cos_mag(logic [63:0] num, logic far);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = far ? (TWO_PI_Q30 * num) / DEN_FAR : (TWO_PI_Q30 * num) / DEN_NEAR;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = clamp_sub(((x2 * t) >> 30) / 64'd132);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd90);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd56);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd30);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd12);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd2);
		return t;
	endfunction

	// (1 + cos) / 2 in q30, folded onto a quarter wave
	function automatic logic [30:0] table_entry(int k);
		logic [63:0] d;
		logic [63:0] kk;
		logic [63:0] f;
		logic [63:0] c;
		d  = DEN_NEAR;
		kk = 64'(k);
		f  = (kk * 2 > d) ? (d - kk) : kk;
		if (4 * f <= d) begin
			c = cos_mag(f, 1'b0);
			return 31'(Q30_HALF + (c >> 1));
		end
		c = cos_mag(d - 2 * f, 1'b1);
		return 31'(Q30_HALF - (c >> 1));
	endfunction

	logic [30:0] cos_rom [COSINE_TABLE_DEPTH];

	for (genvar g = 0; g < COSINE_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [30:0] W = table_entry(g);
		assign cos_rom[g] = W;
	end

	be_t           dv_s [QW+1];
	logic [QW:0]   dv_vld_s;
	logic          en;
	logic          vld_s1, vld_s2;
	logic [2:0]    op_s1, op_s2;
	logic [7:0]    flr_s1, flr_s2;
	logic [7:0]    val_s1, val_s2;
	logic [30:0]   w_s1;
	logic [7:0]    lvl_s2;
	logic          out_vld_q;
	logic [7:0]    brightness_q;

	// setup of the second division
	logic [15:0]   h;
	logic [16:0]   ps;
	logic [15:0]   tb;
	logic [NW-1:0] num;
	logic [15:0]   dsr;
	be_t           head;

	// after the division
	logic [QW-1:0] q;
	logic [7:0]    val;
	logic [AW-1:0] k;
	logic [7:0]    scale;
	logic [38:0]   prod;

	function automatic be_t div_step(be_t a);
		be_t         b;
		logic [16:0] t;
		b = a;
		t = {a.rem, a.dvd[QW-1]};
		if (t >= {1'b0, a.dsr}) begin
			t = t - {1'b0, a.dsr};
		end
		b.rem = t[15:0];
		b.dvd = {a.dvd[QW-2:0], (t != {a.rem, a.dvd[QW-1]})};
		return b;
	endfunction

	assign en    = !out_vld_q || !out_stall;
	assign q_pop = q_nonempty && en;

	always_comb begin
		h  = q_data.per >> 1;
		ps = {1'b0, q_data.r} + {1'b0, h};
		if (ps >= {1'b0, q_data.per}) begin
			ps = ps - {1'b0, q_data.per};
		end
		tb  = (q_data.r < h) ? q_data.r : (q_data.per - q_data.r);
		dsr = q_data.per;
		case (q_data.op)
			OP_SAW: begin
				num = (NW'(q_data.r) << 8) - NW'(q_data.r);
			end
			OP_TRIANGLE: begin
				num = (NW'(tb) << 8) - NW'(tb);
				dsr = (h == 16'd0) ? 16'd1 : h;
			end
			OP_BREATH, OP_BREATH_FLOOR: begin
				num = NW'(ps[15:0]) * NW'(COSINE_TABLE_DEPTH);
			end
			default: begin
				num = '0;
			end
		endcase
		head.op  = q_data.op;
		head.flr = q_data.flr;
		head.hz  = (h == 16'd0);
		head.lt  = (q_data.r < h);
		head.dsr = dsr;
		head.rem = num[NW-1:QW];
		head.dvd = num[QW-1:0];
	end

	always_comb begin
		q = dv_s[QW].dvd;
		k = q[AW-1:0];
		case (dv_s[QW].op)
			OP_STROBE:   val = dv_s[QW].lt ? MAX_LEVEL : 8'd0;
			OP_SAW:      val = q[7:0];
			OP_TRIANGLE: begin
				val = (dv_s[QW].hz || q[QW-1:8] != '0) ? MAX_LEVEL : q[7:0];
			end
			default:     val = 8'd0;
		endcase
		scale = (op_s1 == OP_BREATH_FLOOR) ? (MAX_LEVEL - flr_s1) : MAX_LEVEL;
		prod  = 39'(w_s1) * 39'(scale);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s  <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			dv_vld_s  <= {dv_vld_s[QW-1:0], q_nonempty};
			vld_s1    <= dv_vld_s[QW];
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= head;
			for (int i = 1; i <= QW; i++) begin
				dv_s[i] <= div_step(dv_s[i-1]);
			end
			w_s1   <= cos_rom[k];
			op_s1  <= dv_s[QW].op;
			flr_s1 <= dv_s[QW].flr;
			val_s1 <= val;
			lvl_s2 <= prod[37:30];
			op_s2  <= op_s1;
			flr_s2 <= flr_s1;
			val_s2 <= val_s1;
			case (op_s2)
				OP_BREATH:       brightness_q <= lvl_s2;
				OP_BREATH_FLOOR: brightness_q <= flr_s2 + lvl_s2;
				default:         brightness_q <= val_s2;
			endcase
		end
	end

	assign out_valid  = out_vld_q;
	assign brightness = brightness_q;

endmodule

// File: rtl/led_brightness_waveform_generator.sv
// throughput: one transaction per cycle unless stalled, set by the
// bit-per-stage remainder and quotient pipes
// a four-entry queue parts the time reduction from the waveform back end
// reset: arst_n clears all valid bits and queue pointers at once; no clearing pass
// the cosine rom is constant logic built at elaboration
module led_brightness_waveform_generator
	import lbw_pkg::*;
#(
	parameter int COSINE_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic signed [31:0] phase_offset,
	input  logic [15:0] cycle_length,
	input  logic [7:0]  floor_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  brightness
);

	// front to queue
	logic  q_push;
	logic  q_full;
	item_t q_wdata;

	// queue to back
	logic  q_pop;
	logic  q_nonempty;
	item_t q_rdata;

	// front: elapsed time and its remainder modulo the period, 33 stages
	lbw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.now_ms       (now_ms),
		.phase_offset (phase_offset),
		.cycle_length (cycle_length),
		.floor_level  (floor_level),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	// short queue so front and back stall independently
	lbw_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	// back: waveform division, cosine rom, scaling and output register
	lbw_back #(
		.COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.brightness (brightness)
	);

endmodule

// File: dv/led_brightness_waveform_generator_test.sv
`timescale 1ns / 100ps

module led_brightness_waveform_generator_test;
	import lbw_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int LATENCY = 46;
	localparam longint UNIT_Q30 = 64'd1 << 30;
	localparam longint HALF_Q30 = 64'd1 << 29;
	localparam longint TWO_PI_Q30 = 64'd6746518852;

	// one request as the driver presents it
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now;
		logic [31:0] offs;
		logic [15:0] per;
		logic [7:0]  flr;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [31:0] now_ms = '0;
	logic signed [31:0] phase_offset = '0;
	logic [15:0] cycle_length = 16'd2;
	logic [7:0] floor_level = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] brightness;

	request_t pending_requests[$];
	logic [7:0] expected_levels[$];
	longint cosine_rom[TABLE_DEPTH];
	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	led_brightness_waveform_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.now_ms(now_ms),
		.phase_offset(phase_offset),
		.cycle_length(cycle_length),
		.floor_level(floor_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.brightness(brightness)
	);

	always #4 clk = ~clk;

	// quarter-wave cosine magnitude in q30, nested taylor form with clamps
	function automatic longint cos_quarter(longint num, longint den);
		longint divisors[6];
		longint x, x2, t, sub;
		divisors = '{132, 90, 56, 30, 12, 2};
		x = (TWO_PI_Q30 * num) / den;
		x2 = (x * x) >>> 30;
		t = UNIT_Q30;
		for (int i = 0; i < 6; i++) begin
			sub = ((x2 * t) >>> 30) / divisors[i];
			t = (sub >= UNIT_Q30) ? 0 : UNIT_Q30 - sub;
		end
		return t;
	endfunction

	// raised cosine weight (1 + cos) / 2 for one rom index
	function automatic longint raised_cosine(int k);
		longint f, c;
		f = (2 * k > TABLE_DEPTH) ? TABLE_DEPTH - k : k;
		if (4 * f <= TABLE_DEPTH) begin
			c = cos_quarter(f, TABLE_DEPTH);
			return HALF_Q30 + (c >>> 1);
		end
		c = cos_quarter(TABLE_DEPTH - 2 * f, 2 * TABLE_DEPTH);
		return HALF_Q30 - (c >>> 1);
	endfunction

	// brightness predicted for one request
	function automatic logic [7:0] predict_level(request_t rq);
		logic [31:0] elapsed, per, r, half, v, p;
		longint k, w;
		logic [31:0] level;
		per = (rq.per == 0) ? 32'd1 : {16'd0, rq.per};
		elapsed = rq.now - rq.offs;
		r = elapsed % per;
		half = per / 2;
		level = 0;
		case (rq.op)
			OP_STROBE: level = (r < half) ? 32'd255 : 32'd0;
			OP_SAW: level = (r * 255) / per;
			OP_TRIANGLE: begin
				if (half == 0) begin
					level = 255;
				end else begin
					v = (r < half) ? (r * 255) / half : ((per - r) * 255) / half;
					level = (v > 255) ? 32'd255 : v;
				end
			end
			OP_BREATH, OP_BREATH_FLOOR: begin
				p = (r + half) % per;
				k = (longint'(p) * TABLE_DEPTH) / per;
				w = cosine_rom[k];
				if (rq.op == OP_BREATH)
					level = 32'((w * 255) >>> 30);
				else
					level = rq.flr + 32'((w * (255 - rq.flr)) >>> 30);
			end
			default: level = 0;
		endcase
		return level[7:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// driver: presents the queue head, holding it until accepted
	always @(posedge clk) begin
		request_t rq;
		if (arst_n) begin
			if (!(in_valid && in_stall)) begin
				if (in_valid)
					expected_levels.push_back(predict_level({opcode, now_ms,
						phase_offset, cycle_length, floor_level}));
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					rq = pending_requests.pop_front();
					in_valid <= 1'b1;
					opcode <= rq.op;
					now_ms <= rq.now;
					phase_offset <= rq.offs;
					cycle_length <= rq.per;
					floor_level <= rq.flr;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: each accepted brightness against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_levels.size() == 0)
				report_mismatch("unexpected transaction", brightness, 8'd0);
			else if (brightness !== expected_levels[0])
				report_mismatch("brightness", brightness, expected_levels.pop_front());
			else
				void'(expected_levels.pop_front());
		end
	end

	function automatic request_t random_request();
		request_t rq;
		rq.op = 3'($urandom_range(99) < 92 ? $urandom_range(4) : $urandom_range(7));
		rq.now = $urandom();
		rq.offs = $urandom();
		case ($urandom_range(3))
			0: rq.per = 16'($urandom_range(2, 9));
			1: rq.per = 16'($urandom_range(2, 600));
			2: rq.per = 16'($urandom());
			default: rq.per = 16'($urandom_range(99) < 50 ? 65535 - $urandom_range(3)
				: $urandom_range(0, 1));
		endcase
		rq.flr = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
			: 8'($urandom());
		return rq;
	endfunction

	task automatic wait_drained();
		while (pending_requests.size() > 0 || in_valid || expected_levels.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		request_t rq;
		int idle_modes[4];
		int stall_modes[4];
		idle_modes = '{0, 61, 0, 35};
		stall_modes = '{0, 0, 61, 35};
		for (int k = 0; k < TABLE_DEPTH; k++)
			cosine_rom[k] = raised_cosine(k);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every mode at the field extremes and the corner periods
		for (int op = 0; op < 8; op++) begin
			pending_requests.push_back({3'(op), 32'hFFFF_FFFF, 32'h8000_0000, 16'd65535, 8'd0});
			pending_requests.push_back({3'(op), 32'd0, 32'h7FFF_FFFF, 16'd2, 8'd255});
		end
		pending_requests.push_back({OP_TRIANGLE, 32'd0, 32'd0, 16'd0, 8'd0});
		pending_requests.push_back({OP_BREATH, 32'd5, 32'd0, 16'd1, 8'd0});
		pending_requests.push_back({OP_STROBE, 32'd0, 32'd0, 16'd1, 8'd0});
		pending_requests.push_back({OP_TRIANGLE, 32'd3, 32'd0, 16'd7, 8'd0});   // odd peak
		pending_requests.push_back({OP_TRIANGLE, 32'd4, 32'd0, 16'd7, 8'd0});
		pending_requests.push_back({OP_BREATH_FLOOR, 32'd50, 32'd0, 16'd100, 8'd128});
		pending_requests.push_back({OP_SAW, 32'd0, 32'hFFFF_FFFF, 16'd65535, 8'd0});
		wait_drained();

		// random phases across the idling and stalling mixes
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_modes[phase];
			stall_pct = stall_modes[phase];
			for (int n = 0; n < 175; n++) begin
				rq = random_request();
				pending_requests.push_back(rq);
			end
			wait_drained();  // sender holds off until the pipe is empty
		end
		stall_pct = 0;
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: led_brightness_waveform_generator.f
rtl/lbw_pkg.sv
rtl/lbw_front.sv
rtl/lbw_fifo.sv
rtl/lbw_back.sv
rtl/led_brightness_waveform_generator.sv
dv/led_brightness_waveform_generator_test.sv
